// File: design/shuffled_playlist_sequencer_defines.svh
// Assertion macros for the shuffled playlist sequencer.
// Sampled on clk, disabled while rst_n is low; empty bodies in synthesis.
`ifndef SHUFFLED_PLAYLIST_SEQUENCER_DEFINES_SVH
`define SHUFFLED_PLAYLIST_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
`define SPS_ASSERT_SAME(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("sps assertion failed");
`define SPS_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("sps assertion failed");
`else
`define SPS_ASSERT_SAME(label, cond, expr)
`define SPS_ASSERT_NEXT(label, cond, expr)
`endif

`endif

// File: design/sps_pkg.sv
// Shared types and constants for the shuffled playlist sequencer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sps_pkg;

    localparam int MAX_TRACKS_DEF = 256;
    localparam int FUNC_W         = 2;
    localparam int RAND_W         = 32;
    localparam int CFG_W          = 9;
    localparam int OUT_TRACK_W    = 8;
    localparam int OUT_DRAWS_W    = 8;
    localparam int DIV_STEPS      = RAND_W;
    localparam int STEP_W         = $clog2(DIV_STEPS);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TOGGLE = 2'd0,
        FUNC_NEXT   = 2'd1,
        FUNC_PREV   = 2'd2,
        FUNC_DRAW   = 2'd3
    } func_t;

endpackage

`default_nettype wire

// File: design/sps_req_if.sv
// Request channel of the shuffled playlist sequencer: operation and random word.
// Depends on sps_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sps_req_if import sps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [RAND_W-1:0] random_word;

    modport source (output valid, output func, output random_word, input ready);
    modport sink   (input valid, input func, input random_word, output ready);
endinterface

`default_nettype wire

// File: design/sps_rsp_if.sv
// Result channel of the shuffled playlist sequencer.
// Depends on sps_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sps_rsp_if import sps_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   moved;
    logic [OUT_TRACK_W-1:0] current_track;
    logic                   list_end;
    logic                   shuffle_on;
    logic [OUT_DRAWS_W-1:0] draws_left;

    modport source (output valid, output moved, output current_track, output list_end,
                    output shuffle_on, output draws_left, input ready);
    modport sink   (input valid, input moved, input current_track, input list_end,
                    input shuffle_on, input draws_left, output ready);
endinterface

`default_nettype wire

// File: design/sps_cfg_if.sv
// Configuration write channel of the shuffled playlist sequencer: track count.
// Depends on sps_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sps_cfg_if import sps_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] track_count;

    modport source (output valid, output track_count, input ready);
    modport sink   (input valid, input track_count, output ready);
endinterface

`default_nettype wire

// File: design/shuffled_playlist_sequencer.sv
// Shuffled playlist sequencer top level: order table memory, sequencer and remainder unit.
// Depends on sps_pkg, sps_req_if, sps_rsp_if, sps_cfg_if and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "shuffled_playlist_sequencer_defines.svh"

// After reset the block loads the identity order into every entry of its table memory;
// requests are held off during that pass, configuration writes are not.
// Each request then yields one result. A toggle, a plain next/prev, a refused request or
// a draw with no swaps pending goes straight to the result; a next/prev in shuffle mode
// first does one table read. A draw first forms the bit-serial remainder of the random
// word by the cursor plus one, then does two reads and two writes on the table memory.
// A new request is taken while the previous result still waits in the output register.
module shuffled_playlist_sequencer import sps_pkg::*; #(
    parameter int MAX_TRACKS = MAX_TRACKS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    sps_req_if.sink   req,
    sps_rsp_if.source rsp,
    sps_cfg_if.sink   cfg
);

    localparam int W     = $clog2(MAX_TRACKS);
    localparam int CNT_W = $clog2(MAX_TRACKS + 1);
    localparam logic [W-1:0]     ONE_W   = 1;
    localparam logic [CNT_W-1:0] ONE_CNT = 1;
    localparam logic [W-1:0]     LAST_IX = W'(MAX_TRACKS - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_NAV   = 9'b000000100,
        S_DIV   = 9'b000001000,
        S_RD_C  = 9'b000010000,
        S_RD_J  = 9'b000100000,
        S_WR_C  = 9'b001000000,
        S_WR_J  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    logic [W-1:0] order_mem [MAX_TRACKS];
    logic [W-1:0] rd_data_reg;
    logic         rd_en;
    logic [W-1:0] rd_addr;
    logic         wr_en;
    logic [W-1:0] wr_addr;
    logic [W-1:0] wr_data;

    state_t              state_reg, state_next;
    func_t               func_reg, func_next;
    logic [CFG_W-1:0]    track_count_reg, track_count_next;
    logic                mode_reg, mode_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic [W-1:0]        track_reg, track_next;
    logic [W-1:0]        cursor_reg, cursor_next;
    logic                end_reg, end_next;
    logic                moved_reg, moved_next;
    logic [CNT_W-1:0]    nav_pos_reg, nav_pos_next;
    logic [RAND_W-1:0]   dividend_reg, dividend_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    div_d_reg, div_d_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [W-1:0]        tc_reg, tc_next;
    logic [W-1:0]        clr_reg, clr_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_moved_reg, out_moved_next;
    logic [OUT_TRACK_W-1:0] out_track_reg, out_track_next;
    logic                   out_end_reg, out_end_next;
    logic                   out_mode_reg, out_mode_next;
    logic [OUT_DRAWS_W-1:0] out_draws_reg, out_draws_next;

    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] n_m1;
    logic [CNT_W-1:0] pos_m1;
    logic [CNT_W-1:0] trk_inc;
    logic [CNT_W-1:0] trk_dec;
    logic [CNT_W:0]   rem_sh;
    logic [CNT_W:0]   rem_diff;

    always_comb
    begin
        if (track_count_reg == '0)
        begin
            n_eff = ONE_CNT;
        end
        else if (32'(track_count_reg) > 32'(MAX_TRACKS))
        begin
            n_eff = CNT_W'(MAX_TRACKS);
        end
        else
        begin
            n_eff = CNT_W'(track_count_reg);
        end
    end

    assign n_m1     = n_eff - ONE_CNT;
    assign pos_m1   = pos_reg - ONE_CNT;
    assign trk_inc  = CNT_W'(track_reg) + ONE_CNT;
    assign trk_dec  = CNT_W'(track_reg) - ONE_CNT;
    assign rem_sh   = {rem_reg, dividend_reg[RAND_W-1]};
    assign rem_diff = rem_sh - {1'b0, div_d_reg};

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid         = out_valid_reg;
    assign rsp.moved         = out_moved_reg;
    assign rsp.current_track = out_track_reg;
    assign rsp.list_end      = out_end_reg;
    assign rsp.shuffle_on    = out_mode_reg;
    assign rsp.draws_left    = out_draws_reg;

    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        track_count_next = track_count_reg;
        mode_next        = mode_reg;
        pos_next         = pos_reg;
        track_next       = track_reg;
        cursor_next      = cursor_reg;
        end_next         = end_reg;
        moved_next       = moved_reg;
        nav_pos_next     = nav_pos_reg;
        dividend_next    = dividend_reg;
        rem_next         = rem_reg;
        div_d_next       = div_d_reg;
        step_next        = step_reg;
        tc_next          = tc_reg;
        clr_next         = clr_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_moved_next   = out_moved_reg;
        out_track_next   = out_track_reg;
        out_end_next     = out_end_reg;
        out_mode_next    = out_mode_reg;
        out_draws_next   = out_draws_reg;
        rd_en            = 1'b0;
        rd_addr          = '0;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = '0;

        if (cfg.valid)
        begin
            track_count_next = cfg.track_count;
        end

        case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = clr_reg;
                clr_next = clr_reg + ONE_W;
                if (clr_reg == LAST_IX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next  = func_t'(req.func);
                    moved_next = 1'b0;
                    state_next = S_DONE;
                    case (func_t'(req.func))
                        FUNC_TOGGLE:
                        begin
                            if (!mode_reg)
                            begin
                                mode_next   = 1'b1;
                                pos_next    = '0;
                                cursor_next = n_m1[W-1:0];
                            end
                            else
                            begin
                                mode_next = 1'b0;
                            end
                        end
                        FUNC_NEXT:
                        begin
                            if (mode_reg)
                            begin
                                if (pos_reg < n_eff)
                                begin
                                    rd_en        = 1'b1;
                                    rd_addr      = pos_reg[W-1:0];
                                    nav_pos_next = pos_reg;
                                    state_next   = S_NAV;
                                end
                            end
                            else if (trk_inc < n_eff)
                            begin
                                track_next = trk_inc[W-1:0];
                                end_next   = (trk_inc == n_m1);
                                moved_next = 1'b1;
                            end
                        end
                        FUNC_PREV:
                        begin
                            if (mode_reg)
                            begin
                                if (pos_reg != '0)
                                begin
                                    rd_en        = 1'b1;
                                    rd_addr      = pos_m1[W-1:0];
                                    nav_pos_next = pos_m1;
                                    state_next   = S_NAV;
                                end
                            end
                            else if (track_reg != '0)
                            begin
                                track_next = trk_dec[W-1:0];
                                end_next   = (trk_dec == n_m1);
                                moved_next = 1'b1;
                            end
                        end
                        FUNC_DRAW:
                        begin
                            if (cursor_reg != '0)
                            begin
                                dividend_next = req.random_word;
                                rem_next      = '0;
                                div_d_next    = CNT_W'(cursor_reg) + ONE_CNT;
                                step_next     = '0;
                                state_next    = S_DIV;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_NAV:
            begin
                track_next = rd_data_reg;
                end_next   = (nav_pos_reg == n_m1);
                moved_next = 1'b1;
                pos_next   = (func_reg == FUNC_NEXT) ? nav_pos_reg + ONE_CNT : nav_pos_reg;
                state_next = S_DONE;
            end
            S_DIV:
            begin
                // restoring remainder, one dividend bit per cycle
                if (!rem_diff[CNT_W])
                begin
                    rem_next = rem_diff[CNT_W-1:0];
                end
                else
                begin
                    rem_next = rem_sh[CNT_W-1:0];
                end
                dividend_next = {dividend_reg[RAND_W-2:0], 1'b0};
                step_next     = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_RD_C;
                end
            end
            S_RD_C:
            begin
                rd_en      = 1'b1;
                rd_addr    = cursor_reg;
                state_next = S_RD_J;
            end
            S_RD_J:
            begin
                tc_next    = rd_data_reg;
                rd_en      = 1'b1;
                rd_addr    = rem_reg[W-1:0];
                state_next = S_WR_C;
            end
            S_WR_C:
            begin
                wr_en      = 1'b1;
                wr_addr    = cursor_reg;
                wr_data    = rd_data_reg;
                state_next = S_WR_J;
            end
            S_WR_J:
            begin
                wr_en       = 1'b1;
                wr_addr     = rem_reg[W-1:0];
                wr_data     = tc_reg;
                cursor_next = cursor_reg - ONE_W;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_moved_next = moved_reg;
                    out_track_next = OUT_TRACK_W'(track_reg);
                    out_end_next   = end_reg;
                    out_mode_next  = mode_reg;
                    out_draws_next = OUT_DRAWS_W'(cursor_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            order_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= order_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            track_count_reg <= CFG_W'(1);
            mode_reg        <= 1'b0;
            pos_reg         <= '0;
            track_reg       <= '0;
            cursor_reg      <= '0;
            end_reg         <= 1'b0;
            clr_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            track_count_reg <= track_count_next;
            mode_reg        <= mode_next;
            pos_reg         <= pos_next;
            track_reg       <= track_next;
            cursor_reg      <= cursor_next;
            end_reg         <= end_next;
            clr_reg         <= clr_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        moved_reg     <= moved_next;
        nav_pos_reg   <= nav_pos_next;
        dividend_reg  <= dividend_next;
        rem_reg       <= rem_next;
        div_d_reg     <= div_d_next;
        step_reg      <= step_next;
        tc_reg        <= tc_next;
        out_moved_reg <= out_moved_next;
        out_track_reg <= out_track_next;
        out_end_reg   <= out_end_next;
        out_mode_reg  <= out_mode_next;
        out_draws_reg <= out_draws_next;
    end

    // swap index must be a valid remainder before the table is touched
    `SPS_ASSERT_SAME(a_rem_below_divisor, state_reg == S_RD_C, rem_reg < div_d_reg)
    `SPS_ASSERT_NEXT(a_cursor_steps_down, state_reg == S_WR_J, cursor_reg == $past(cursor_reg) - ONE_W)
    `SPS_ASSERT_NEXT(a_result_not_dropped, (state_reg == S_DONE) && out_valid_reg && !rsp.ready, (state_reg == S_DONE) && out_valid_reg)

endmodule

`default_nettype wire
